### rtl/core/lsc_pkg.sv
// Shared types and constants for the LRU slot cache.
// Holds the controller-to-datapath command group, register indexes and result codes.
// No dependencies.
package lsc_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int MAX_EXPERTS   = 256;

    localparam int ID_W       = 8;
    localparam int SLOT_OUT_W = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam int CAP_W      = 5;

    localparam logic [CFG_IDX_W-1:0] REG_EXPERT_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 1'd1;

    localparam logic [CFG_DATA_W-1:0] EXPERT_COUNT_RESET = 9'd256;
    localparam logic [CAP_W-1:0]      CAPACITY_RESET     = 5'd16;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

    typedef struct packed {
        logic load;
        logic match;
        logic locate;
        logic commit;
    } lsc_cmd_t;

endpackage

### rtl/core/lru_slot_cache.sv
// LRU slot cache: a request runs the match, locate and update steps over the
// recency list and is taken only once the previous one has been committed;
// the update step holds while the result register is full.
// Reset is synchronous: list emptied, expert_count 256, capacity 16.
// A capacity write flushes the list in the same cycle.
module lru_slot_cache #(
    parameter int MAX_SLOTS = lsc_pkg::MAX_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [lsc_pkg::ID_W-1:0]         s_expert_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [lsc_pkg::SLOT_OUT_W-1:0]   m_slot,
    output logic [lsc_pkg::STATUS_W-1:0]     m_status,
    input  logic                             cfg_wr_en,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    lsc_pkg::lsc_cmd_t cmd;

    lsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lsc_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_op        (s_op),
        .s_expert_id (s_expert_id),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .m_hit       (m_hit),
        .m_slot      (m_slot),
        .m_status    (m_status)
    );

endmodule

### rtl/core/lsc_ctrl.sv
// Sequencing controller for the LRU slot cache.
// Steps each request through match, locate and update; owns the result valid flag.
// Depends on lsc_pkg.
module lsc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output lsc_pkg::lsc_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_LOCATE = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd.load   = s_valid && (state_reg == ST_IDLE);
        cmd.match  = (state_reg == ST_MATCH);
        cmd.locate = (state_reg == ST_LOCATE);
        cmd.commit = (state_reg == ST_UPDATE) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_LOCATE;
            ST_LOCATE: state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/core/lsc_datapath.sv
// Datapath of the LRU slot cache: recency list, counters, config registers, result register.
// Free slots are always the low end of the slot range, so the free stack reduces to a count.
// Depends on lsc_pkg.
module lsc_datapath #(
    parameter int MAX_SLOTS = lsc_pkg::MAX_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lsc_pkg::lsc_cmd_t                cmd,
    input  logic                             s_op,
    input  logic [lsc_pkg::ID_W-1:0]         s_expert_id,
    input  logic                             cfg_wr_en,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output logic                             m_hit,
    output logic [lsc_pkg::SLOT_OUT_W-1:0]   m_slot,
    output logic [lsc_pkg::STATUS_W-1:0]     m_status
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RC_W  = $clog2(MAX_SLOTS + 1);
    localparam int EXT_W = (IDX_W > lsc_pkg::SLOT_OUT_W) ? IDX_W : lsc_pkg::SLOT_OUT_W;
    localparam logic [RC_W-1:0] RC_ONE = RC_W'(1);

    function automatic logic [RC_W-1:0] eff_cap(input logic [lsc_pkg::CAP_W-1:0] v);
        logic [RC_W-1:0] r;
        if (v == '0) begin
            r = RC_ONE;
        end else if (int'(v) > MAX_SLOTS) begin
            r = RC_W'(MAX_SLOTS);
        end else begin
            r = RC_W'(v);
        end
        return r;
    endfunction

    logic [lsc_pkg::CFG_DATA_W-1:0] expert_count_reg;
    logic [RC_W-1:0]                cap_reg;
    logic [RC_W-1:0]                rc_reg;
    logic [RC_W-1:0]                rc_next;

    logic                           op_reg;
    logic [lsc_pkg::ID_W-1:0]       id_reg;

    logic [lsc_pkg::ID_W-1:0]       ids_reg   [MAX_SLOTS];
    logic [IDX_W-1:0]               slots_reg [MAX_SLOTS];

    logic [MAX_SLOTS-1:0]           match_reg;
    logic [MAX_SLOTS-1:0]           match_next;
    logic                           bad_reg;
    logic                           bad_next;

    logic                           hit_reg;
    logic [IDX_W-1:0]               pos_reg;
    logic [IDX_W-1:0]               pos_enc;
    logic [IDX_W-1:0]               rd_idx;
    logic [IDX_W-1:0]               rd_slot_reg;

    logic                           full;
    logic [IDX_W-1:0]               last_idx;
    logic [IDX_W-1:0]               free_top;
    logic                           list_upd;
    logic [IDX_W-1:0]               shift_pos;
    logic [IDX_W-1:0]               res_slot;
    logic                           res_hit;
    logic [lsc_pkg::STATUS_W-1:0]   res_status;
    logic [EXT_W-1:0]               slot_ext;

    logic                           m_hit_reg;
    logic [lsc_pkg::SLOT_OUT_W-1:0] m_slot_reg;
    logic [lsc_pkg::STATUS_W-1:0]   m_status_reg;

    assign m_hit    = m_hit_reg;
    assign m_slot   = m_slot_reg;
    assign m_status = m_status_reg;

    always_comb begin
        match_next = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            match_next[i] = (RC_W'(i) < rc_reg) && (ids_reg[i] == id_reg);
        end
        bad_next = ({1'b0, id_reg} >= expert_count_reg) ||
                   (int'(id_reg) >= lsc_pkg::MAX_EXPERTS);
    end

    always_comb begin
        pos_enc = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (match_reg[i]) begin
                pos_enc = pos_enc | IDX_W'(i);
            end
        end
    end

    assign last_idx = IDX_W'(rc_reg - RC_ONE);
    assign free_top = IDX_W'(cap_reg - rc_reg - RC_ONE);
    assign rd_idx   = (|match_reg) ? pos_enc : last_idx;
    assign full     = (rc_reg >= cap_reg);

    always_comb begin
        res_hit    = 1'b0;
        res_slot   = '0;
        res_status = lsc_pkg::STATUS_OK;
        list_upd   = 1'b0;
        shift_pos  = pos_reg;
        rc_next    = rc_reg;
        if (bad_reg) begin
            res_status = lsc_pkg::STATUS_BAD_ID;
        end else if (hit_reg) begin
            res_hit  = 1'b1;
            res_slot = rd_slot_reg;
            list_upd = (op_reg == lsc_pkg::OP_UPDATE);
        end else if (op_reg == lsc_pkg::OP_FIND) begin
            res_status = lsc_pkg::STATUS_ABSENT;
        end else if (full) begin
            res_slot  = rd_slot_reg;
            list_upd  = 1'b1;
            shift_pos = last_idx;
        end else begin
            res_slot  = free_top;
            list_upd  = 1'b1;
            shift_pos = IDX_W'(rc_reg);
            rc_next   = rc_reg + RC_ONE;
        end
    end

    assign slot_ext = EXT_W'(res_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expert_count_reg <= lsc_pkg::EXPERT_COUNT_RESET;
            cap_reg          <= eff_cap(lsc_pkg::CAPACITY_RESET);
            rc_reg           <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lsc_pkg::REG_EXPERT_COUNT: expert_count_reg <= cfg_wdata;
                lsc_pkg::REG_CAPACITY: begin
                    cap_reg <= eff_cap(cfg_wdata[lsc_pkg::CAP_W-1:0]);
                    rc_reg  <= '0;
                end
                default: ;
            endcase
        end else if (cmd.commit) begin
            rc_reg <= rc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_op;
            id_reg <= s_expert_id;
        end
        if (cmd.match) begin
            match_reg <= match_next;
            bad_reg   <= bad_next;
        end
        if (cmd.locate) begin
            hit_reg     <= |match_reg;
            pos_reg     <= pos_enc;
            rd_slot_reg <= slots_reg[rd_idx];
        end
        if (cmd.commit) begin
            m_hit_reg    <= res_hit;
            m_slot_reg   <= slot_ext[lsc_pkg::SLOT_OUT_W-1:0];
            m_status_reg <= res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && list_upd) begin
            ids_reg[0]   <= id_reg;
            slots_reg[0] <= res_slot;
            for (int i = 1; i < MAX_SLOTS; i++) begin
                if (IDX_W'(i) <= shift_pos) begin
                    ids_reg[i]   <= ids_reg[i-1];
                    slots_reg[i] <= slots_reg[i-1];
                end
            end
        end
    end

endmodule

### rtl/core/lsc_checker.sv
// Port-level assertions for the LRU slot cache, attached by bind.
// Depends on lsc_pkg and on the ports of lru_slot_cache.
module lsc_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_hit,
    input logic [lsc_pkg::SLOT_OUT_W-1:0]   m_slot,
    input logic [lsc_pkg::STATUS_W-1:0]     m_status
);

    a_error_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != lsc_pkg::STATUS_OK) |-> !m_hit && (m_slot == '0))
        else $error("error result carries hit or slot");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> (m_status == lsc_pkg::STATUS_OK))
        else $error("hit result with error status");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input transfer accepted while a request is in flight");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_slot)
            && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind lru_slot_cache lsc_checker u_lsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_hit    (m_hit),
    .m_slot   (m_slot),
    .m_status (m_status)
);

### tb/lru_cache_monitor.sv
// Monitor for the LRU slot cache: tracks register writes and request transfers,
// keeps its own copy of the recency list and the free-slot stack, and checks results.
// Depends on lsc_pkg.
module lru_cache_monitor
    import lsc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic                    s_op,
    input  logic [ID_W-1:0]         s_expert_id,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    m_hit,
    input  logic [SLOT_OUT_W-1:0]   m_slot,
    input  logic [STATUS_W-1:0]     m_status,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    output int                      fail_count,
    output int                      outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS = MAX_SLOTS_DEF;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic [STATUS_W-1:0]   status;
    } cache_reply_t;

    logic [CFG_DATA_W-1:0] id_limit;
    logic [CAP_W-1:0]      cap_reg;
    logic [ID_W-1:0]       lru_ids [NSLOTS];
    logic [SLOT_OUT_W-1:0] lru_slots [NSLOTS];
    logic [SLOT_OUT_W-1:0] free_stack [NSLOTS];
    bit                    resident_map [MAX_EXPERTS];
    int unsigned           resident_cnt;
    int unsigned           free_cnt;
    cache_reply_t          replies_due [$];

    function automatic int unsigned cap_in_use();
        if (cap_reg == 0) return 1;
        if (cap_reg > NSLOTS) return NSLOTS;
        return cap_reg;
    endfunction

    function automatic void flush_cache();
        int unsigned n;
        n = cap_in_use();
        for (int i = 0; i < NSLOTS; i++) begin
            lru_ids[i] = '0;
            lru_slots[i] = '0;
            free_stack[i] = '0;
        end
        for (int i = 0; i < MAX_EXPERTS; i++) resident_map[i] = 1'b0;
        for (int i = 0; i < n; i++) free_stack[i] = SLOT_OUT_W'(i);
        resident_cnt = 0;
        free_cnt = n;
    endfunction

    function automatic void bring_to_front(input int unsigned pos, input logic [ID_W-1:0] id,
                                           input logic [SLOT_OUT_W-1:0] s);
        int unsigned p;
        p = (pos >= NSLOTS) ? NSLOTS - 1 : pos;
        for (int unsigned i = p; i > 0; i--) begin
            lru_ids[i] = lru_ids[i-1];
            lru_slots[i] = lru_slots[i-1];
        end
        lru_ids[0] = id;
        lru_slots[0] = s;
    endfunction

    function automatic cache_reply_t serve_request(input logic op, input logic [ID_W-1:0] id);
        cache_reply_t r;
        int unsigned pos;
        int unsigned last;
        r = '0;
        r.status = STATUS_OK;
        if (CFG_DATA_W'(id) >= id_limit) begin
            r.status = STATUS_BAD_ID;
        end else if (resident_map[id]) begin
            r.hit = 1'b1;
            pos = resident_cnt;
            for (int unsigned i = 0; i < resident_cnt && i < NSLOTS; i++) begin
                if (pos == resident_cnt && lru_ids[i] == id) pos = i;
            end
            if (pos < resident_cnt) begin
                r.slot = lru_slots[pos];
                if (op == OP_UPDATE) bring_to_front(pos, id, r.slot);
            end
        end else if (op == OP_FIND) begin
            r.status = STATUS_ABSENT;
        end else begin
            if (resident_cnt >= cap_in_use() && resident_cnt > 0) begin
                last = resident_cnt - 1;
                resident_map[lru_ids[last]] = 1'b0;
                if (free_cnt < NSLOTS) begin
                    free_stack[free_cnt] = lru_slots[last];
                    free_cnt++;
                end
                resident_cnt = last;
            end
            if (free_cnt > 0 && resident_cnt < NSLOTS) begin
                free_cnt--;
                r.slot = free_stack[free_cnt];
                bring_to_front(resident_cnt, id, r.slot);
                resident_cnt++;
                resident_map[id] = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin : track
        cache_reply_t want;
        if (!aresetn) begin
            id_limit = EXPERT_COUNT_RESET;
            cap_reg = CAPACITY_RESET;
            flush_cache();
            replies_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_EXPERT_COUNT) begin
                    id_limit = cfg_wdata;
                end else if (cfg_index == REG_CAPACITY) begin
                    cap_reg = cfg_wdata[CAP_W-1:0];
                    flush_cache();
                end
            end
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected result transfer: hit %0d slot %0d status %0d",
                           m_hit, m_slot, m_status);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, m_hit);
                        fail_count++;
                    end
                    if (m_slot !== want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, m_slot);
                        fail_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                replies_due = {replies_due, serve_request(s_op, s_expert_id)};
            end
        end
        outstanding = replies_due.size();
    end

endmodule

### tb/tb_lru_slot_cache.sv
// Testbench top for the LRU slot cache: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Result checking lives in lru_cache_monitor.
// Depends on lsc_pkg, lru_slot_cache and lru_cache_monitor.
module tb_lru_slot_cache;
    timeunit 1ns;
    timeprecision 1ps;
    import lsc_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_op;
    logic [ID_W-1:0]       s_expert_id;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic [STATUS_W-1:0]   m_status;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    outstanding;

    int cur_limit;
    int cur_cap;
    int ws_base;

    lru_slot_cache dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_expert_id(s_expert_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_slot(m_slot),
        .m_status(m_status),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    lru_cache_monitor monitor (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_expert_id(s_expert_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_slot(m_slot),
        .m_status(m_status),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("** lru_slot_cache: FAILED **");
        $finish;
    end

    initial begin : result_stall
        int cycle;
        int mode;
        int hold;
        cycle = 0;
        mode = 0;
        hold = 0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (cycle % 50 == 0) mode = $urandom_range(0, 2);
            cycle++;
            if (mode == 0) begin
                m_ready <= 1'b1;
            end else if (mode == 1) begin
                m_ready <= 1'($urandom_range(0, 1));
            end else if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) hold = $urandom_range(4, 14);
            end
        end
    end

    task automatic send_request(input logic op, input logic [ID_W-1:0] id);
        s_valid <= 1'b1;
        s_op <= op;
        s_expert_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic reconfigure(input logic [CFG_DATA_W-1:0] limit,
                               input logic [CFG_DATA_W-1:0] cap_word, input bit reload);
        int span;
        int c;
        settle();
        write_reg(REG_EXPERT_COUNT, limit);
        cur_limit = limit;
        if (reload) begin
            write_reg(REG_CAPACITY, cap_word);
            c = cap_word[CAP_W-1:0];
            cur_cap = (c == 0) ? 1 : (c > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : c;
        end
        span = (cur_limit > MAX_EXPERTS) ? MAX_EXPERTS : cur_limit;
        ws_base = (span > cur_cap + 3) ? $urandom_range(0, span - cur_cap - 3) : 0;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        int id;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            id = ws_base + $urandom_range(0, cur_cap + 2);
        end else if (r < 85) begin
            id = $urandom_range(0, MAX_EXPERTS - 1);
        end else begin
            id = cur_limit - 2 + $urandom_range(0, 3);
            if (id < 0) id = 0;
            if (id > MAX_EXPERTS - 1) id = MAX_EXPERTS - 1;
        end
        return ID_W'(id);
    endfunction

    task automatic run_phase(input int n);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_request(($urandom_range(0, 9) < 3) ? OP_FIND : OP_UPDATE, pick_id());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            if ($urandom_range(0, 39) == 0) settle();
        end
    endtask

    initial begin
        s_valid <= 1'b0;
        s_op <= OP_UPDATE;
        s_expert_id <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_EXPERT_COUNT;
        cfg_wdata <= '0;
        aresetn <= 1'b0;
        cur_limit = EXPERT_COUNT_RESET;
        cur_cap = CAPACITY_RESET;
        ws_base = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(OP_FIND, 8'd0);
        send_request(OP_UPDATE, 8'd0);
        send_request(OP_UPDATE, 8'd255);
        send_request(OP_FIND, 8'd255);
        send_request(OP_UPDATE, 8'd0);
        send_request(OP_FIND, 8'd0);

        reconfigure(9'd200, 9'd2, 1'b1);
        send_request(OP_UPDATE, 8'd10);
        send_request(OP_UPDATE, 8'd20);
        send_request(OP_UPDATE, 8'd10);
        send_request(OP_UPDATE, 8'd30);
        send_request(OP_FIND, 8'd20);
        send_request(OP_FIND, 8'd10);
        send_request(OP_UPDATE, 8'd199);
        send_request(OP_UPDATE, 8'd200);
        send_request(OP_FIND, 8'd200);
        send_request(OP_FIND, 8'd255);

        reconfigure(9'd15, 9'd2, 1'b0);
        send_request(OP_FIND, 8'd10);
        send_request(OP_FIND, 8'd199);
        send_request(OP_UPDATE, 8'd199);
        send_request(OP_UPDATE, 8'd14);
        send_request(OP_UPDATE, 8'd3);
        send_request(OP_FIND, 8'd14);

        reconfigure(9'd256, 9'd16, 1'b1);
        run_phase(150);
        reconfigure(9'd256, 9'd5, 1'b1);
        run_phase(150);
        reconfigure(9'd0, 9'd5, 1'b0);
        run_phase(30);
        reconfigure(9'd511, 9'd1, 1'b1);
        run_phase(120);
        reconfigure(9'd300, 9'd0, 1'b1);
        run_phase(120);
        reconfigure(9'd64, 9'd31, 1'b1);
        run_phase(150);
        reconfigure(9'd256, 9'd17, 1'b1);
        run_phase(150);
        reconfigure(9'd40, 9'd8, 1'b1);
        run_phase(150);
        reconfigure(9'd20, 9'd8, 1'b0);
        run_phase(100);
        reconfigure(9'd256, 9'd3, 1'b1);
        run_phase(150);
        reconfigure(9'd1, 9'd16, 1'b1);
        run_phase(50);

        settle();
        repeat (16) @(negedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("** lru_slot_cache: PASSED **");
        end else begin
            $display("** lru_slot_cache: FAILED **");
        end
        $finish;
    end

endmodule

### lru_slot_cache.f
rtl/core/lsc_pkg.sv
rtl/core/lsc_ctrl.sv
rtl/core/lsc_datapath.sv
rtl/core/lru_slot_cache.sv
rtl/core/lsc_checker.sv
tb/lru_cache_monitor.sv
tb/tb_lru_slot_cache.sv
